[rtl/tgo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgo_pkg
// Shared types, widths, register indexes and the 6x10 glyph table of the
// text glyph overlay.
// ----------------------------------------------------------------------------
package tgo_pkg;

   // fixed field widths
   localparam int CFG_COORD_W = 12;
   localparam int CHARS_W     = 56;
   localparam int CODE_W      = 7;
   localparam int LEN_W       = 4;
   localparam int PIX_W       = 8;
   localparam int SHIFT_W     = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 56;

   // glyph cell geometry
   localparam int GLYPH_W     = 6;
   localparam int GLYPH_H     = 10;
   localparam int GLYPH_BITS  = GLYPH_W * GLYPH_H;
   localparam int GLYPH_LO_W  = 32;
   localparam int GLYPH_HI_W  = GLYPH_BITS - GLYPH_LO_W;
   localparam int DY_W        = 4;
   localparam int BITPOS_W    = 6;
   localparam int XCELL_W     = 3;

   // column offset inside the box is below 6 * 8 = 48
   localparam int DX_W        = 6;
   localparam int CHAR_IDX_W  = 3;
   // floor(d / 6) == (d * 43) >> 8 for every d below 48
   localparam int RECIP_6     = 43;
   localparam int RECIP_SHIFT = 8;
   localparam int PROD_W      = 2 * DX_W;

   // parameter defaults
   localparam int MAX_CHARS_DEF  = 8;
   localparam int COORD_BITS_DEF = 12;

   // register reset values
   localparam logic [PIX_W-1:0] FOREGROUND_RST = 8'hFF;
   localparam logic             DIM_MODE_RST   = 1'b1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLUMN  = 3'd0,
      CSR_TEXT_ROW     = 3'd1,
      CSR_TEXT_CHARS   = 3'd2,
      CSR_TEXT_LENGTH  = 3'd3,
      CSR_FOREGROUND   = 3'd4,
      CSR_SHIFT_AMOUNT = 3'd5,
      CSR_DIM_MODE     = 3'd6
   } csr_index_type;

   // configuration handed from the register block to the datapath
   typedef struct packed {
      logic [CFG_COORD_W-1:0] text_column;
      logic [CFG_COORD_W-1:0] text_row;
      logic [CHARS_W-1:0]     text_chars;
      logic [LEN_W-1:0]       text_length;
      logic [PIX_W-1:0]       foreground;
      logic [SHIFT_W-1:0]     shift_amount;
      logic                   dim_mode;
   } cfg_type;

   // glyph bitmap, bit y*6+x; upper 28 bits over lower 32 bits
   function automatic logic [GLYPH_BITS-1:0] glyph_rom(input logic [CODE_W-1:0] code);
      logic [GLYPH_HI_W-1:0] hi;
      logic [GLYPH_LO_W-1:0] lo;
      hi = '0;
      lo = '0;
      case (code)
         7'h2B: begin lo = 32'h1F104000; hi = 28'h0000041; end // plus
         7'h2D: begin lo = 32'h1F000000; hi = 28'h0000000; end // minus
         7'h2E: begin lo = 32'h00000000; hi = 28'h10E1000; end // period
         7'h30: begin lo = 32'h51451284; hi = 28'h0042914; end
         7'h31: begin lo = 32'h04105184; hi = 28'h01F1041; end
         7'h32: begin lo = 32'h0841144E; hi = 28'h01F0421; end
         7'h33: begin lo = 32'h0E10841F; hi = 28'h00E4504; end
         7'h34: begin lo = 32'h4A28C208; hi = 28'h00821F2; end
         7'h35: begin lo = 32'h1334105F; hi = 28'h00E4504; end
         7'h36: begin lo = 32'h4F04144E; hi = 28'h00E4514; end
         7'h37: begin lo = 32'h0420841F; hi = 28'h0020821; end
         7'h38: begin lo = 32'h4E45144E; hi = 28'h00E4514; end
         7'h39: begin lo = 32'h1E45144E; hi = 28'h00E4504; end
         7'h41: begin lo = 32'hD1451284; hi = 28'h0114517; end
         7'h42: begin lo = 32'h8E49248F; hi = 28'h00F4924; end
         7'h43: begin lo = 32'h4104144E; hi = 28'h00E4410; end
         7'h44: begin lo = 32'h9249248F; hi = 28'h00F4924; end
         7'h45: begin lo = 32'h4F04105F; hi = 28'h01F0410; end
         7'h46: begin lo = 32'h4F04105F; hi = 28'h0010410; end
         7'h47: begin lo = 32'h4104144E; hi = 28'h00E4516; end
         7'h48: begin lo = 32'h5F451451; hi = 28'h0114514; end
         7'h49: begin lo = 32'h0410410E; hi = 28'h00E1041; end
         7'h4A: begin lo = 32'h0820821C; hi = 28'h0062482; end
         7'h4B: begin lo = 32'h43149451; hi = 28'h0114491; end
         7'h4C: begin lo = 32'h41041041; hi = 28'h01F0410; end
         7'h4D: begin lo = 32'h5555B451; hi = 28'h0114514; end
         7'h4E: begin lo = 32'h555534D1; hi = 28'h0114596; end
         7'h4F: begin lo = 32'h5145144E; hi = 28'h00E4514; end
         7'h50: begin lo = 32'h4F45144F; hi = 28'h0010410; end
         7'h51: begin lo = 32'h5145144E; hi = 28'h40E5514; end
         7'h52: begin lo = 32'h4F45144F; hi = 28'h0114491; end
         7'h53: begin lo = 32'h0E04144E; hi = 28'h00E4504; end
         7'h54: begin lo = 32'h0410411F; hi = 28'h0041041; end
         7'h55: begin lo = 32'h51451451; hi = 28'h00E4514; end
         7'h56: begin lo = 32'h8A451451; hi = 28'h00410A2; end
         7'h57: begin lo = 32'h55451451; hi = 28'h00A5555; end
         7'h58: begin lo = 32'h8428A451; hi = 28'h01144A2; end
         7'h59: begin lo = 32'h0428A451; hi = 28'h0041041; end
         7'h5A: begin lo = 32'h8420841F; hi = 28'h01F0420; end
         default: begin lo = '0; hi = '0; end // blank glyph
      endcase
      return {hi, lo};
   endfunction

endpackage
`default_nettype wire

[rtl/tgo_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgo interfaces
// Valid/ready channels of the text glyph overlay: pixel request, pixel
// response and register write.
// ----------------------------------------------------------------------------

// pixel request channel
interface tgo_req_if import tgo_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_column;
   logic [COORD_BITS-1:0] pixel_row;
   logic [PIX_W-1:0]      pixel_in;

   modport source (output valid, output pixel_column, output pixel_row,
                   output pixel_in, input ready);
   modport sink   (input valid, input pixel_column, input pixel_row,
                   input pixel_in, output ready);
endinterface

// pixel response channel
interface tgo_rsp_if import tgo_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             inside_text;

   modport source (output valid, output pixel_out, output inside_text, input ready);
   modport sink   (input valid, input pixel_out, input inside_text, output ready);
endinterface

// register write channel
interface tgo_csr_if import tgo_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/tgo_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgo_csr
// Configuration registers of the text glyph overlay, written one beat at a
// time through the register write channel.
// ----------------------------------------------------------------------------
module tgo_csr import tgo_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tgo_csr_if.sink    csr_if,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_if.ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_TEXT_COLUMN:  cfg_in.text_column  = csr_if.data[CFG_COORD_W-1:0];
            CSR_TEXT_ROW:     cfg_in.text_row     = csr_if.data[CFG_COORD_W-1:0];
            CSR_TEXT_CHARS:   cfg_in.text_chars   = csr_if.data[CHARS_W-1:0];
            CSR_TEXT_LENGTH:  cfg_in.text_length  = csr_if.data[LEN_W-1:0];
            CSR_FOREGROUND:   cfg_in.foreground   = csr_if.data[PIX_W-1:0];
            CSR_SHIFT_AMOUNT: cfg_in.shift_amount = csr_if.data[SHIFT_W-1:0];
            CSR_DIM_MODE:     cfg_in.dim_mode     = csr_if.data[0];
            default:          cfg_in = cfg_ff; // unused index, write dropped
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_column  <= '0;
         cfg_ff.text_row     <= '0;
         cfg_ff.text_chars   <= '0;
         cfg_ff.text_length  <= '0;
         cfg_ff.foreground   <= FOREGROUND_RST;
         cfg_ff.shift_amount <= '0;
         cfg_ff.dim_mode     <= DIM_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/text_glyph_overlay_unit.sv]
`default_nettype none
// Throughput: one pixel per cycle while the response side is not stalled;
// four pipeline stages (box test, cell split, glyph lookup, output mux)
// each hold one pixel, and a stage advances only when the next has room.
// Reset: clears all stage valid bits and loads the registers with column 0,
// row 0, empty string, length 0, foreground 255, shift 0 and dim mode on.
// ----------------------------------------------------------------------------
// text_glyph_overlay_unit
// Per-pixel on-screen text overlay with a fixed 6x10 glyph table.
// ----------------------------------------------------------------------------
module text_glyph_overlay_unit import tgo_pkg::*; #(
   parameter int MAX_CHARS  = MAX_CHARS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tgo_req_if.sink     req_if,
   tgo_rsp_if.source   rsp_if,
   tgo_csr_if.sink     csr_if
);

   localparam int CMP_W = ((COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W) + 1;

   cfg_type cfg;

   // register block
   tgo_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // stage advance, from the output backwards
   logic adv1, adv2, adv3, adv4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign adv4 = !v4_ff || rsp_if.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_if.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_if.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage 1: box test
   logic [CMP_W-1:0]  dx_full, dy_full;
   logic [LEN_W-1:0]  len_sat;
   logic [DX_W-1:0]   x_limit;
   logic              inside1_in;
   logic              inside1_ff;
   logic [DX_W-1:0]   dx1_ff;
   logic [DY_W-1:0]   dy1_ff;
   logic [PIX_W-1:0]  pix1_ff;

   always_comb begin
      dx_full = CMP_W'(req_if.pixel_column) - CMP_W'(cfg.text_column);
      dy_full = CMP_W'(req_if.pixel_row) - CMP_W'(cfg.text_row);
      len_sat = (cfg.text_length > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : cfg.text_length;
      x_limit = DX_W'(len_sat) * DX_W'(GLYPH_W);
      inside1_in = !dx_full[CMP_W-1] && !dy_full[CMP_W-1]
                && (dx_full[CMP_W-2:0] < (CMP_W-1)'(x_limit))
                && (dy_full[CMP_W-2:0] < (CMP_W-1)'(GLYPH_H));
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         inside1_ff <= inside1_in;
         dx1_ff     <= dx_full[DX_W-1:0];
         dy1_ff     <= dy_full[DY_W-1:0];
         pix1_ff    <= req_if.pixel_in;
      end
   end

   // stage 2: split the column offset into character index and cell column
   logic [PROD_W-1:0]     prod;
   logic [CHAR_IDX_W-1:0] idx2_in;
   logic [XCELL_W-1:0]    xcell;
   logic [BITPOS_W-1:0]   bitpos2_in;
   logic                  inside2_ff;
   logic [CHAR_IDX_W-1:0] idx2_ff;
   logic [BITPOS_W-1:0]   bitpos2_ff;
   logic [PIX_W-1:0]      pix2_ff;

   always_comb begin
      prod    = PROD_W'(dx1_ff) * PROD_W'(RECIP_6);
      idx2_in = prod[RECIP_SHIFT +: CHAR_IDX_W];
      xcell   = XCELL_W'(dx1_ff - DX_W'(idx2_in) * DX_W'(GLYPH_W));
      bitpos2_in = BITPOS_W'(dy1_ff) * BITPOS_W'(GLYPH_W) + BITPOS_W'(xcell);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         inside2_ff <= inside1_ff;
         idx2_ff    <= idx2_in;
         bitpos2_ff <= bitpos2_in;
         pix2_ff    <= pix1_ff;
      end
   end

   // stage 3: glyph lookup and background shift
   logic [CODE_W-1:0]         code;
   logic [(1<<BITPOS_W)-1:0]  glyph;
   logic                      fg3_in;
   logic [PIX_W-1:0]          bg3_in;
   logic                      inside3_ff;
   logic                      fg3_ff;
   logic [PIX_W-1:0]          bg3_ff;
   logic [PIX_W-1:0]          pix3_ff;

   always_comb begin
      code   = cfg.text_chars[BITPOS_W'(CODE_W) * BITPOS_W'(idx2_ff) +: CODE_W];
      glyph  = (1<<BITPOS_W)'(glyph_rom(code));
      fg3_in = glyph[bitpos2_ff];
      priority if (cfg.shift_amount == '0) begin
         bg3_in = pix2_ff;
      end else if (cfg.shift_amount >= SHIFT_W'(PIX_W)) begin
         bg3_in = '0;
      end else if (cfg.dim_mode) begin
         bg3_in = pix2_ff >> cfg.shift_amount[2:0];
      end else begin
         bg3_in = pix2_ff << cfg.shift_amount[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         inside3_ff <= inside2_ff;
         fg3_ff     <= fg3_in;
         bg3_ff     <= bg3_in;
         pix3_ff    <= pix2_ff;
      end
   end

   // stage 4: output select, held while the response is stalled
   logic [PIX_W-1:0] pix4_in;
   logic [PIX_W-1:0] pix4_ff;
   logic             inside4_ff;

   always_comb begin
      priority if (!inside3_ff) begin
         pix4_in = pix3_ff;
      end else if (fg3_ff) begin
         pix4_in = cfg.foreground;
      end else begin
         pix4_in = bg3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         pix4_ff    <= pix4_in;
         inside4_ff <= inside3_ff;
      end
   end

   assign rsp_if.valid       = v4_ff;
   assign rsp_if.pixel_out   = pix4_ff;
   assign rsp_if.inside_text = inside4_ff;

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_overlay_unit testbench
// Streams pixels through the overlay under random source gaps and sink
// stalls and checks every response beat against a local overlay predictor.
// Registers are reloaded between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module testbench import tgo_pkg::*;;

   localparam int CELL_W      = 6;
   localparam int CELL_H      = 10;
   localparam int TEXT_SLOTS  = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_TAIL  = 8;

   typedef struct packed {
      logic [CFG_COORD_W-1:0] pixel_column;
      logic [CFG_COORD_W-1:0] pixel_row;
      logic [PIX_W-1:0]       pixel_in;
   } pixel_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             inside_text;
   } overlay_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tgo_req_if #(.COORD_BITS(CFG_COORD_W)) req_if ();
   tgo_rsp_if rsp_if ();
   tgo_csr_if csr_if ();

   text_glyph_overlay_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cfg_type            overlay_cfg;
   pixel_beat_type     pending_pixels[$];
   overlay_result_type expected_pixels[$];
   int                 queued_count   = 0;
   int                 accepted_count = 0;
   int                 mismatch_count = 0;
   int                 cycle_count    = 0;
   bit                 req_taken      = 1'b0;
   bit                 rsp_taken      = 1'b0;
   int                 req_hold       = 0;
   int                 rsp_hold       = 0;
   int                 req_stretch    = 0;
   int                 rsp_stretch    = 0;
   bit                 req_idle_on    = 1'b0;
   bit                 rsp_idle_on    = 1'b0;

   // 6x10 glyph bitmaps as {upper 28 bits, lower 32 bits}, bit y*6+x
   function automatic logic [59:0] glyph_cells(input logic [CODE_W-1:0] code);
      case (code)
         7'h2B: return 60'h0000041_1F104000; // plus
         7'h2D: return 60'h0000000_1F000000; // minus
         7'h2E: return 60'h10E1000_00000000; // period
         7'h30: return 60'h0042914_51451284;
         7'h31: return 60'h01F1041_04105184;
         7'h32: return 60'h01F0421_0841144E;
         7'h33: return 60'h00E4504_0E10841F;
         7'h34: return 60'h00821F2_4A28C208;
         7'h35: return 60'h00E4504_1334105F;
         7'h36: return 60'h00E4514_4F04144E;
         7'h37: return 60'h0020821_0420841F;
         7'h38: return 60'h00E4514_4E45144E;
         7'h39: return 60'h00E4504_1E45144E;
         7'h41: return 60'h0114517_D1451284;
         7'h42: return 60'h00F4924_8E49248F;
         7'h43: return 60'h00E4410_4104144E;
         7'h44: return 60'h00F4924_9249248F;
         7'h45: return 60'h01F0410_4F04105F;
         7'h46: return 60'h0010410_4F04105F;
         7'h47: return 60'h00E4516_4104144E;
         7'h48: return 60'h0114514_5F451451;
         7'h49: return 60'h00E1041_0410410E;
         7'h4A: return 60'h0062482_0820821C;
         7'h4B: return 60'h0114491_43149451;
         7'h4C: return 60'h01F0410_41041041;
         7'h4D: return 60'h0114514_5555B451;
         7'h4E: return 60'h0114596_555534D1;
         7'h4F: return 60'h00E4514_5145144E;
         7'h50: return 60'h0010410_4F45144F;
         7'h51: return 60'h40E5514_5145144E;
         7'h52: return 60'h0114491_4F45144F;
         7'h53: return 60'h00E4504_0E04144E;
         7'h54: return 60'h0041041_0410411F;
         7'h55: return 60'h00E4514_51451451;
         7'h56: return 60'h00410A2_8A451451;
         7'h57: return 60'h00A5555_55451451;
         7'h58: return 60'h01144A2_8428A451;
         7'h59: return 60'h0041041_0428A451;
         7'h5A: return 60'h01F0420_8420841F;
         default: return '0; // blank glyph
      endcase
   endfunction

   // overlay of one pixel under the current register set
   function automatic overlay_result_type predict_overlay(input pixel_beat_type beat);
      overlay_result_type result;
      int unsigned        span;
      int unsigned        dx;
      int unsigned        dy;
      int unsigned        slot;
      logic [59:0]        cells;
      span = (overlay_cfg.text_length > TEXT_SLOTS) ? TEXT_SLOTS
                                                    : 32'(overlay_cfg.text_length);
      result.pixel_out   = beat.pixel_in;
      result.inside_text = 1'b0;
      if (beat.pixel_column >= overlay_cfg.text_column &&
          beat.pixel_row >= overlay_cfg.text_row) begin
         dx = 32'(beat.pixel_column) - 32'(overlay_cfg.text_column);
         dy = 32'(beat.pixel_row) - 32'(overlay_cfg.text_row);
         if (dx < CELL_W * span && dy < CELL_H) begin
            slot  = dx / CELL_W;
            cells = glyph_cells(overlay_cfg.text_chars[BITPOS_W'(CODE_W * slot) +: CODE_W]);
            result.inside_text = 1'b1;
            if (cells[BITPOS_W'(dy * CELL_W + dx % CELL_W)]) begin
               result.pixel_out = overlay_cfg.foreground;
            end else if (overlay_cfg.shift_amount != 0) begin
               if (overlay_cfg.shift_amount >= 8)
                  result.pixel_out = '0;
               else if (overlay_cfg.dim_mode)
                  result.pixel_out = beat.pixel_in >> overlay_cfg.shift_amount;
               else
                  result.pixel_out = beat.pixel_in << overlay_cfg.shift_amount;
            end
         end
      end
      return result;
   endfunction

   // wait before the next beat: idle and busy stretches are drawn at random
   function automatic int draw_wait(inout int stretch, inout bit idle_on);
      if (stretch == 0) begin
         stretch = $urandom_range(8, 48);
         idle_on = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      return idle_on ? $urandom_range(0, 4) : 0;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // pixel source: one beat per handshake, random gaps between beats
   always @(negedge clock) begin : drive_pixels
      int             wait_cycles;
      pixel_beat_type beat;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_hold     <= 0;
      end else if (!req_if.valid || req_taken) begin
         wait_cycles = req_taken ? draw_wait(req_stretch, req_idle_on) : req_hold;
         if (wait_cycles != 0) begin
            req_if.valid <= 1'b0;
            req_hold     <= wait_cycles - 1;
         end else if (pending_pixels.size() != 0) begin
            beat = pending_pixels.pop_front();
            req_if.pixel_column <= beat.pixel_column;
            req_if.pixel_row    <= beat.pixel_row;
            req_if.pixel_in     <= beat.pixel_in;
            req_if.valid        <= 1'b1;
            req_hold            <= 0;
         end else begin
            req_if.valid <= 1'b0;
            req_hold     <= 0;
         end
      end
   end

   // response sink: random stall after each taken beat
   always @(negedge clock) begin : pace_responses
      int wait_cycles;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         wait_cycles = rsp_taken ? draw_wait(rsp_stretch, rsp_idle_on) : rsp_hold;
         if (wait_cycles != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold     <= wait_cycles - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_hold     <= 0;
         end
      end
   end

   // predict on each request beat, check each response beat
   always @(posedge clock) begin : watch_beats
      pixel_beat_type     beat;
      overlay_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            beat.pixel_column = req_if.pixel_column;
            beat.pixel_row    = req_if.pixel_row;
            beat.pixel_in     = req_if.pixel_in;
            expected_pixels.push_back(predict_overlay(beat));
            accepted_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               note_mismatch("response beat with nothing outstanding");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_if.pixel_out !== want.pixel_out)
                  note_mismatch($sformatf("pixel_out expected %02h got %02h",
                                          want.pixel_out, rsp_if.pixel_out));
               if (rsp_if.inside_text !== want.inside_text)
                  note_mismatch($sformatf("inside_text expected %0b got %0b",
                                          want.inside_text, rsp_if.inside_text));
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL text_glyph_overlay_unit");
         $finish;
      end
   end

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.index <= index;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         CSR_TEXT_COLUMN:  overlay_cfg.text_column  = value[CFG_COORD_W-1:0];
         CSR_TEXT_ROW:     overlay_cfg.text_row     = value[CFG_COORD_W-1:0];
         CSR_TEXT_CHARS:   overlay_cfg.text_chars   = value[CHARS_W-1:0];
         CSR_TEXT_LENGTH:  overlay_cfg.text_length  = value[LEN_W-1:0];
         CSR_FOREGROUND:   overlay_cfg.foreground   = value[PIX_W-1:0];
         CSR_SHIFT_AMOUNT: overlay_cfg.shift_amount = value[SHIFT_W-1:0];
         CSR_DIM_MODE:     overlay_cfg.dim_mode     = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_overlay(input cfg_type setup);
      write_register(CSR_TEXT_COLUMN, CSR_DATA_W'(setup.text_column));
      write_register(CSR_TEXT_ROW, CSR_DATA_W'(setup.text_row));
      write_register(CSR_TEXT_CHARS, CSR_DATA_W'(setup.text_chars));
      write_register(CSR_TEXT_LENGTH, CSR_DATA_W'(setup.text_length));
      write_register(CSR_FOREGROUND, CSR_DATA_W'(setup.foreground));
      write_register(CSR_SHIFT_AMOUNT, CSR_DATA_W'(setup.shift_amount));
      write_register(CSR_DIM_MODE, CSR_DATA_W'(setup.dim_mode));
   endtask

   task automatic queue_pixel(input logic [CFG_COORD_W-1:0] column,
                              input logic [CFG_COORD_W-1:0] row,
                              input logic [PIX_W-1:0] value);
      pixel_beat_type beat;
      beat.pixel_column = column;
      beat.pixel_row    = row;
      beat.pixel_in     = value;
      @(posedge clock);
      pending_pixels.push_back(beat);
      queued_count++;
   endtask

   // stimulus waits until every queued pixel is taken and answered
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [CFG_COORD_W-1:0] pick_origin();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return CFG_COORD_W'(4095 - $urandom_range(0, 60));
         default: return CFG_COORD_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // mostly drawable codes, some arbitrary ones
   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned n;
      n = $urandom_range(0, 49);
      if (n < 10) return 7'h30 + CODE_W'(n);
      if (n < 36) return 7'h41 + CODE_W'(n - 10);
      case (n)
         36: return 7'h2B;
         37: return 7'h2D;
         38: return 7'h2E;
         default: return CODE_W'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic cfg_type random_overlay_setup();
      cfg_type setup;
      int      k;
      setup.text_column = pick_origin();
      setup.text_row    = pick_origin();
      for (k = 0; k < TEXT_SLOTS; k++)
         setup.text_chars[BITPOS_W'(CODE_W*k) +: CODE_W] = pick_code();
      setup.text_length = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 15))
                                                      : LEN_W'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
         0: setup.foreground = '0;
         1: setup.foreground = '1;
         default: setup.foreground = PIX_W'($urandom_range(0, 255));
      endcase
      setup.shift_amount = ($urandom_range(0, 3) == 0) ? SHIFT_W'($urandom_range(8, 15))
                                                       : SHIFT_W'($urandom_range(0, 7));
      setup.dim_mode     = 1'($urandom_range(0, 1));
      return setup;
   endfunction

   // pixels mostly around the text box, the rest anywhere
   task automatic queue_random_pixel();
      int unsigned span;
      logic [CFG_COORD_W-1:0] column;
      logic [CFG_COORD_W-1:0] row;
      logic [PIX_W-1:0]       value;
      span = (overlay_cfg.text_length > TEXT_SLOTS) ? TEXT_SLOTS
                                                    : 32'(overlay_cfg.text_length);
      if ($urandom_range(0, 3) != 0) begin
         column = CFG_COORD_W'(32'(overlay_cfg.text_column)
                               + $urandom_range(0, CELL_W * span + 3) - 2);
         row    = CFG_COORD_W'(32'(overlay_cfg.text_row)
                               + $urandom_range(0, CELL_H + 3) - 2);
      end else begin
         column = CFG_COORD_W'($urandom_range(0, 4095));
         row    = CFG_COORD_W'($urandom_range(0, 4095));
      end
      case ($urandom_range(0, 7))
         0: value = '0;
         1: value = '1;
         default: value = PIX_W'($urandom_range(0, 255));
      endcase
      queue_pixel(column, row, value);
   endtask

   initial begin : stimulus
      cfg_type setup;
      int      phase;
      int      n;
      req_if.valid        = 1'b0;
      req_if.pixel_column = '0;
      req_if.pixel_row    = '0;
      req_if.pixel_in     = '0;
      rsp_if.ready        = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = CSR_TEXT_COLUMN;
      csr_if.data         = '0;
      overlay_cfg              = '0;
      overlay_cfg.foreground   = FOREGROUND_RST;
      overlay_cfg.dim_mode     = DIM_MODE_RST;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values: empty string, no text box
      queue_pixel(12'd0, 12'd0, 8'h5A);
      queue_pixel(12'hFFF, 12'hFFF, 8'hFF);
      wait_drained();

      // full string at the origin: plus, minus, period, '0', 'Z',
      // lower case 'a', code zero and '9'; dim by one
      setup.text_column  = '0;
      setup.text_row     = '0;
      setup.text_chars   = {7'h39, 7'h00, 7'h61, 7'h5A, 7'h30, 7'h2E, 7'h2D, 7'h2B};
      setup.text_length  = 4'd8;
      setup.foreground   = 8'hC3;
      setup.shift_amount = 4'd1;
      setup.dim_mode     = 1'b1;
      load_overlay(setup);
      queue_pixel(12'd0, 12'd0, 8'hFF);
      queue_pixel(12'd2, 12'd2, 8'h00);
      queue_pixel(12'd6, 12'd4, 8'h81);
      queue_pixel(12'd11, 12'd4, 8'h81);
      queue_pixel(12'd14, 12'd7, 8'h40);
      queue_pixel(12'd14, 12'd9, 8'h40);
      queue_pixel(12'd18, 12'd0, 8'h10);
      queue_pixel(12'd24, 12'd0, 8'h10);
      queue_pixel(12'd32, 12'd4, 8'hFE);
      queue_pixel(12'd36, 12'd5, 8'hFE);
      queue_pixel(12'd42, 12'd0, 8'h33);
      queue_pixel(12'd47, 12'd9, 8'h33);
      queue_pixel(12'd48, 12'd0, 8'h77);
      queue_pixel(12'd0, 12'd10, 8'h77);
      queue_pixel(12'd47, 12'd10, 8'h77);
      wait_drained();

      // box running off the far corner, length over the slot count,
      // shift of eight to the left
      setup.text_column  = 12'd4090;
      setup.text_row     = 12'd4088;
      setup.text_chars   = {8{7'h57}};
      setup.text_length  = 4'd15;
      setup.foreground   = 8'hFF;
      setup.shift_amount = 4'd8;
      setup.dim_mode     = 1'b0;
      load_overlay(setup);
      queue_pixel(12'hFFF, 12'hFFF, 8'hAA);
      queue_pixel(12'd4089, 12'd4090, 8'hAA);
      queue_pixel(12'd4090, 12'd4087, 8'hAA);
      queue_pixel(12'hFFF, 12'd4088, 8'h55);
      queue_pixel(12'd4092, 12'd4093, 8'h55);
      wait_drained();

      // random phases, the first two at the register extremes
      for (phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            setup.text_column  = '1;
            setup.text_row     = '1;
            setup.text_chars   = '1;
            setup.text_length  = '1;
            setup.foreground   = '1;
            setup.shift_amount = '1;
            setup.dim_mode     = 1'b1;
         end else if (phase == 1) begin
            setup = '0;
         end else begin
            setup = random_overlay_setup();
         end
         load_overlay(setup);
         for (n = 0; n < 112; n++)
            queue_random_pixel();
         wait_drained();
      end

      repeat (DRAIN_TAIL) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS text_glyph_overlay_unit");
      else
         $display("FAIL text_glyph_overlay_unit");
      $finish;
   end

endmodule
